/* rtl/eapt_pkg.sv */
// ----------------------------------------------------------------------------
// eapt_pkg
// Shared types, constants and the CORDIC arctangent table for the affine
// point transform.
// ----------------------------------------------------------------------------
`default_nettype none

package eapt_pkg;

   localparam int COORD_WIDTH  = 32;   // Q16.16 coordinates
   localparam int FRAC_BITS    = 16;
   localparam int ANG_WIDTH    = 26;   // angles, degrees, Q.16
   localparam int TRIG_WIDTH   = 32;   // cos/sin, Q2.30
   localparam int TRIG_FRAC    = 30;
   localparam int WIDE_WIDTH   = 56;   // intermediate coordinates
   localparam int PROD_SPLIT   = 24;   // low part of a split multiply
   localparam int CORDIC_STEPS = 16;
   localparam int RED_WIDTH    = 25;   // angle reduced into [0, 360)
   localparam int RES_WIDTH    = 23;   // residue in [0, 90)
   localparam int Z_WIDTH      = 26;

   localparam int DEG360       = 23592960;
   localparam int DEG90        = 5898240;
   localparam int CORDIC_START = 652032874;

   // pipeline depths in register stages
   localparam int SC_LAT  = CORDIC_STEPS + 3;
   localparam int ROT_LAT = 4;
   localparam int NST     = 1 + SC_LAT + 3 * ROT_LAT + 1;

   localparam int AX_X = 0;
   localparam int AX_Y = 1;
   localparam int AX_Z = 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [ANG_WIDTH-1:0]   ang_type;
   typedef logic signed [TRIG_WIDTH-1:0]  trig_type;
   typedef logic signed [WIDE_WIDTH-1:0]  wide_type;
   typedef logic signed [Z_WIDTH-1:0]     zang_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } res_type;

   // arctan(2^-i) in degrees, Q.16
   function automatic zang_type atan_step(input int idx);
      zang_type v;
      case (idx)
         0:       v = Z_WIDTH'(2949120);
         1:       v = Z_WIDTH'(1740967);
         2:       v = Z_WIDTH'(919879);
         3:       v = Z_WIDTH'(466945);
         4:       v = Z_WIDTH'(234379);
         5:       v = Z_WIDTH'(117304);
         6:       v = Z_WIDTH'(58666);
         7:       v = Z_WIDTH'(29335);
         8:       v = Z_WIDTH'(14668);
         9:       v = Z_WIDTH'(7334);
         10:      v = Z_WIDTH'(3667);
         11:      v = Z_WIDTH'(1833);
         12:      v = Z_WIDTH'(917);
         13:      v = Z_WIDTH'(458);
         14:      v = Z_WIDTH'(229);
         15:      v = Z_WIDTH'(115);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/eapt_sincos.sv */
// ----------------------------------------------------------------------------
// eapt_sincos
// Pipelined cosine/sine of an angle in degrees: reduce, split into quadrant,
// one CORDIC step per stage, quadrant fold. Q2.30 results.
// ----------------------------------------------------------------------------
`default_nettype none

module eapt_sincos (
   input  logic               clock,
   input  logic               en,
   input  eapt_pkg::ang_type  ang,
   output eapt_pkg::trig_type cos_out,
   output eapt_pkg::trig_type sin_out
);
   import eapt_pkg::*;

   localparam logic signed [ANG_WIDTH:0] D360 = (ANG_WIDTH+1)'(DEG360);
   localparam logic [RED_WIDTH-1:0] R90  = RED_WIDTH'(DEG90);
   localparam logic [RED_WIDTH-1:0] R180 = RED_WIDTH'(2 * DEG90);
   localparam logic [RED_WIDTH-1:0] R270 = RED_WIDTH'(3 * DEG90);

   logic signed [ANG_WIDTH:0] a_wide;
   logic signed [ANG_WIDTH:0] red;
   logic [RED_WIDTH-1:0]      r_in, r_ff;
   logic [1:0]                q0;
   logic [RED_WIDTH-1:0]      t0;

   trig_type   x_ff  [CORDIC_STEPS+1];
   trig_type   y_ff  [CORDIC_STEPS+1];
   zang_type   z_ff  [CORDIC_STEPS+1];
   logic [1:0] q_ff  [CORDIC_STEPS+1];
   logic       zr_ff [CORDIC_STEPS+1];

   trig_type xr, yr, cos_in, sin_in, cos_ff, sin_ff;

   // stage 1: reduce into [0, 360)
   always_comb begin
      a_wide = (ANG_WIDTH+1)'(ang);
      if (a_wide < 0) begin
         red = ((a_wide + D360) < 0) ? (a_wide + D360 + D360) : (a_wide + D360);
      end else begin
         red = (a_wide >= D360) ? (a_wide - D360) : a_wide;
      end
      r_in = red[RED_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
      end
   end

   // stage 2: quadrant and residue
   always_comb begin
      if (r_ff >= R270) begin
         q0 = 2'd3;
         t0 = r_ff - R270;
      end else if (r_ff >= R180) begin
         q0 = 2'd2;
         t0 = r_ff - R180;
      end else if (r_ff >= R90) begin
         q0 = 2'd1;
         t0 = r_ff - R90;
      end else begin
         q0 = 2'd0;
         t0 = r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= TRIG_WIDTH'(CORDIC_START);
         y_ff[0]  <= '0;
         z_ff[0]  <= Z_WIDTH'(t0[RES_WIDTH-1:0]);
         q_ff[0]  <= q0;
         zr_ff[0] <= (t0 == '0);
      end
   end

   // one rotation step per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_step(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_step(i);
            end
            q_ff[i+1]  <= q_ff[i];
            zr_ff[i+1] <= zr_ff[i];
         end
      end
   end

   // quadrant fold; a zero residue is exact
   always_comb begin
      if (zr_ff[CORDIC_STEPS]) begin
         xr = TRIG_WIDTH'(64'sd1 <<< TRIG_FRAC);
         yr = '0;
      end else begin
         xr = x_ff[CORDIC_STEPS];
         yr = y_ff[CORDIC_STEPS];
      end
      case (q_ff[CORDIC_STEPS])
         2'd1: begin
            cos_in = -yr;
            sin_in = xr;
         end
         2'd2: begin
            cos_in = -xr;
            sin_in = -yr;
         end
         2'd3: begin
            cos_in = yr;
            sin_in = -xr;
         end
         default: begin
            cos_in = xr;
            sin_in = yr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

`default_nettype wire

/* rtl/eapt_rot.sv */
// ----------------------------------------------------------------------------
// eapt_rot
// Pipelined plane rotation: a = p*c - q*s, b = p*s + q*c, each product
// rounded half away from zero at the Q2.30 point. Four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module eapt_rot (
   input  logic               clock,
   input  logic               en,
   input  eapt_pkg::wide_type p,
   input  eapt_pkg::wide_type q,
   input  eapt_pkg::trig_type c,
   input  eapt_pkg::trig_type s,
   output eapt_pkg::wide_type a,
   output eapt_pkg::wide_type b
);
   import eapt_pkg::*;

   localparam int HI_W   = WIDE_WIDTH - PROD_SPLIT;
   localparam int FULL_W = WIDE_WIDTH + TRIG_WIDTH;
   localparam int P_PC = 0;
   localparam int P_QS = 1;
   localparam int P_PS = 2;
   localparam int P_QC = 3;

   logic [WIDE_WIDTH-1:0] pm_ff, qm_ff;
   logic [TRIG_WIDTH-1:0] cm_ff, sm_ff;
   logic [3:0]            ng1_ff, ng2_ff, ng_in;

   logic [WIDE_WIDTH-1:0]           mw [4];
   logic [TRIG_WIDTH-1:0]           mt [4];
   logic [HI_W+TRIG_WIDTH-1:0]      hi_ff [4];
   logic [PROD_SPLIT+TRIG_WIDTH-1:0] lo_ff [4];

   logic [FULL_W-1:0] full [4];
   wide_type          rp_in [4];
   wide_type          rp_ff [4];
   wide_type          a_ff, b_ff;

   // stage 1: magnitudes and product signs
   always_comb begin
      ng_in[P_PC] = p[WIDE_WIDTH-1] ^ c[TRIG_WIDTH-1];
      ng_in[P_QS] = q[WIDE_WIDTH-1] ^ s[TRIG_WIDTH-1];
      ng_in[P_PS] = p[WIDE_WIDTH-1] ^ s[TRIG_WIDTH-1];
      ng_in[P_QC] = q[WIDE_WIDTH-1] ^ c[TRIG_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pm_ff  <= p[WIDE_WIDTH-1] ? WIDE_WIDTH'(-p) : WIDE_WIDTH'(p);
         qm_ff  <= q[WIDE_WIDTH-1] ? WIDE_WIDTH'(-q) : WIDE_WIDTH'(q);
         cm_ff  <= c[TRIG_WIDTH-1] ? TRIG_WIDTH'(-c) : TRIG_WIDTH'(c);
         sm_ff  <= s[TRIG_WIDTH-1] ? TRIG_WIDTH'(-s) : TRIG_WIDTH'(s);
         ng1_ff <= ng_in;
      end
   end

   // stage 2: split partial products
   always_comb begin
      mw[P_PC] = pm_ff;
      mt[P_PC] = cm_ff;
      mw[P_QS] = qm_ff;
      mt[P_QS] = sm_ff;
      mw[P_PS] = pm_ff;
      mt[P_PS] = sm_ff;
      mw[P_QC] = qm_ff;
      mt[P_QC] = cm_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            hi_ff[k] <= mw[k][WIDE_WIDTH-1:PROD_SPLIT] * mt[k];
            lo_ff[k] <= mw[k][PROD_SPLIT-1:0] * mt[k];
         end
         ng2_ff <= ng1_ff;
      end
   end

   // stage 3: recombine, round, apply sign
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         full[k]  = {hi_ff[k], {PROD_SPLIT{1'b0}}} + FULL_W'(lo_ff[k])
                  + (FULL_W'(1) << (TRIG_FRAC - 1));
         rp_in[k] = ng2_ff[k] ? -wide_type'(full[k][TRIG_FRAC +: WIDE_WIDTH])
                              :  wide_type'(full[k][TRIG_FRAC +: WIDE_WIDTH]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            rp_ff[k] <= rp_in[k];
         end
      end
   end

   // stage 4: combine
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= rp_ff[P_PC] - rp_ff[P_QS];
         b_ff <= rp_ff[P_PS] + rp_ff[P_QC];
      end
   end

   assign a = a_ff;
   assign b = b_ff;

endmodule

`default_nettype wire

/* rtl/euler_affine_point_transform.sv */
// ----------------------------------------------------------------------------
// euler_affine_point_transform
// out = loc + Rx * Ry * Rz * (scl .* vec), Q16.16, angles in Q10.16 degrees.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one item: vector, translation, three Euler angles
//    and three scale factors. rsp_ channel returns the transformed vector,
//    saturated to the 32-bit Q16.16 range. One result per item, in order.
//  - Throughput: one item per cycle, sustained while the skid is empty.
//  - Depth: 34 register stages from the accepting edge to rsp_valid
//    (input register, 19-stage sine/cosine pipeline with the
//    scale multiply alongside, three 4-stage rotation units Z, Y, X, the
//    translate/clamp stage and the output register). The sine/cosine CORDIC
//    chain accounts for most of these stages.
//  - Stall: every stage advances together; a two-entry output buffer
//    (output register plus skid) takes the item leaving the pipeline, so
//    req_ready is a register and drops only once the skid holds an item.
//  - Reset (synchronous, active high): clears all valid bits and the output
//    buffer; items in flight are dropped. No configuration, no state kept
//    between items.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_affine_point_transform (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  eapt_pkg::coord_type req_vec_x,
   input  eapt_pkg::coord_type req_vec_y,
   input  eapt_pkg::coord_type req_vec_z,
   input  eapt_pkg::coord_type req_loc_x,
   input  eapt_pkg::coord_type req_loc_y,
   input  eapt_pkg::coord_type req_loc_z,
   input  eapt_pkg::ang_type   req_rot_x,
   input  eapt_pkg::ang_type   req_rot_y,
   input  eapt_pkg::ang_type   req_rot_z,
   input  eapt_pkg::coord_type req_scl_x,
   input  eapt_pkg::coord_type req_scl_y,
   input  eapt_pkg::coord_type req_scl_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output eapt_pkg::coord_type rsp_out_x,
   output eapt_pkg::coord_type rsp_out_y,
   output eapt_pkg::coord_type rsp_out_z
);
   import eapt_pkg::*;

   localparam int CW      = COORD_WIDTH;
   localparam int SV_DLY  = SC_LAT - 3;               // scale path is 3 stages
   localparam int LOC_DLY = SC_LAT + 3 * ROT_LAT;
   localparam logic signed [WIDE_WIDTH:0] SUM_MAX =
      (WIDE_WIDTH+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [WIDE_WIDTH:0] SUM_MIN = -SUM_MAX - 1;

   // pipeline enable: whole pipe moves unless the skid is occupied
   logic en;
   logic [NST:1] vld_ff;

   // input register
   coord_type vec_ff [3];
   coord_type loc_ff [3];
   coord_type scl_ff [3];
   ang_type   rot_ff [3];

   // scale path
   logic [CW-1:0]       vm_ff [3];
   logic [CW-1:0]       sm_ff [3];
   logic [2:0]          sn1_ff, sn2_ff;
   logic [2*CW-1:0]     sp_ff [3];
   logic [2*CW-1:0]     sp_rnd [3];
   wide_type            sv_ff [3];
   wide_type            sv_dly_ff [3][SV_DLY];

   coord_type loc_dly_ff [3][LOC_DLY];

   // angle path
   trig_type cs [3];
   trig_type sn [3];
   trig_type cy_dly_ff [ROT_LAT];
   trig_type sy_dly_ff [ROT_LAT];
   trig_type cx_dly_ff [2*ROT_LAT];
   trig_type sx_dly_ff [2*ROT_LAT];

   // rotation chain
   wide_type zx, zy, yx, yz, xy, xz;
   wide_type pz_dly_ff [ROT_LAT];
   wide_type py_dly_ff [ROT_LAT];
   wide_type px_dly_ff [ROT_LAT];

   // translate and clamp
   logic signed [WIDE_WIDTH:0] sum [3];
   coord_type                  fin_in [3];
   res_type                    fin_ff;

   // output buffer
   logic    out_v_ff, out_v_in, sk_v_ff, sk_v_in;
   res_type out_d_ff, out_d_in, sk_d_ff, sk_d_in;

   assign en        = !sk_v_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-1:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff[AX_X] <= req_vec_x;
         vec_ff[AX_Y] <= req_vec_y;
         vec_ff[AX_Z] <= req_vec_z;
         loc_ff[AX_X] <= req_loc_x;
         loc_ff[AX_Y] <= req_loc_y;
         loc_ff[AX_Z] <= req_loc_z;
         scl_ff[AX_X] <= req_scl_x;
         scl_ff[AX_Y] <= req_scl_y;
         scl_ff[AX_Z] <= req_scl_z;
         rot_ff[AX_X] <= req_rot_x;
         rot_ff[AX_Y] <= req_rot_y;
         rot_ff[AX_Z] <= req_rot_z;
      end
   end

   // scale: sign/magnitude, multiply, round half away from zero
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sp_rnd[k] = sp_ff[k] + ((2*CW)'(1) << (FRAC_BITS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            vm_ff[k]  <= vec_ff[k][CW-1] ? CW'(-vec_ff[k]) : CW'(vec_ff[k]);
            sm_ff[k]  <= scl_ff[k][CW-1] ? CW'(-scl_ff[k]) : CW'(scl_ff[k]);
            sn1_ff[k] <= vec_ff[k][CW-1] ^ scl_ff[k][CW-1];
            sp_ff[k]  <= vm_ff[k] * sm_ff[k];
            sn2_ff[k] <= sn1_ff[k];
            sv_ff[k]  <= sn2_ff[k]
                       ? -wide_type'(sp_rnd[k][2*CW-1:FRAC_BITS])
                       :  wide_type'(sp_rnd[k][2*CW-1:FRAC_BITS]);
         end
      end
   end

   // line the scaled vector and translation up with the trig results
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sv_dly_ff[k][0]  <= sv_ff[k];
            loc_dly_ff[k][0] <= loc_ff[k];
            for (int j = 1; j < SV_DLY; j++) begin
               sv_dly_ff[k][j] <= sv_dly_ff[k][j-1];
            end
            for (int j = 1; j < LOC_DLY; j++) begin
               loc_dly_ff[k][j] <= loc_dly_ff[k][j-1];
            end
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_trig
      eapt_sincos u_sincos (
         .clock   (clock),
         .en      (en),
         .ang     (rot_ff[k]),
         .cos_out (cs[k]),
         .sin_out (sn[k])
      );
   end

   // about Z
   eapt_rot u_rot_z (
      .clock (clock),
      .en    (en),
      .p     (sv_dly_ff[AX_X][SV_DLY-1]),
      .q     (sv_dly_ff[AX_Y][SV_DLY-1]),
      .c     (cs[AX_Z]),
      .s     (sn[AX_Z]),
      .a     (zx),
      .b     (zy)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         pz_dly_ff[0] <= sv_dly_ff[AX_Z][SV_DLY-1];
         cy_dly_ff[0] <= cs[AX_Y];
         sy_dly_ff[0] <= sn[AX_Y];
         cx_dly_ff[0] <= cs[AX_X];
         sx_dly_ff[0] <= sn[AX_X];
         py_dly_ff[0] <= zy;
         px_dly_ff[0] <= yx;
         for (int j = 1; j < ROT_LAT; j++) begin
            pz_dly_ff[j] <= pz_dly_ff[j-1];
            cy_dly_ff[j] <= cy_dly_ff[j-1];
            sy_dly_ff[j] <= sy_dly_ff[j-1];
            py_dly_ff[j] <= py_dly_ff[j-1];
            px_dly_ff[j] <= px_dly_ff[j-1];
         end
         for (int j = 1; j < 2*ROT_LAT; j++) begin
            cx_dly_ff[j] <= cx_dly_ff[j-1];
            sx_dly_ff[j] <= sx_dly_ff[j-1];
         end
      end
   end

   // about Y: x' = c x + s z, z' = c z - s x
   eapt_rot u_rot_y (
      .clock (clock),
      .en    (en),
      .p     (pz_dly_ff[ROT_LAT-1]),
      .q     (zx),
      .c     (cy_dly_ff[ROT_LAT-1]),
      .s     (sy_dly_ff[ROT_LAT-1]),
      .a     (yz),
      .b     (yx)
   );

   // about X
   eapt_rot u_rot_x (
      .clock (clock),
      .en    (en),
      .p     (py_dly_ff[ROT_LAT-1]),
      .q     (yz),
      .c     (cx_dly_ff[2*ROT_LAT-1]),
      .s     (sx_dly_ff[2*ROT_LAT-1]),
      .a     (xy),
      .b     (xz)
   );

   // translate and clamp to the coordinate range
   always_comb begin
      sum[AX_X] = (WIDE_WIDTH+1)'(loc_dly_ff[AX_X][LOC_DLY-1]) + (WIDE_WIDTH+1)'(px_dly_ff[ROT_LAT-1]);
      sum[AX_Y] = (WIDE_WIDTH+1)'(loc_dly_ff[AX_Y][LOC_DLY-1]) + (WIDE_WIDTH+1)'(xy);
      sum[AX_Z] = (WIDE_WIDTH+1)'(loc_dly_ff[AX_Z][LOC_DLY-1]) + (WIDE_WIDTH+1)'(xz);
      for (int k = 0; k < 3; k++) begin
         if (sum[k] > SUM_MAX) begin
            fin_in[k] = SUM_MAX[CW-1:0];
         end else if (sum[k] < SUM_MIN) begin
            fin_in[k] = SUM_MIN[CW-1:0];
         end else begin
            fin_in[k] = sum[k][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff.x <= fin_in[AX_X];
         fin_ff.y <= fin_in[AX_Y];
         fin_ff.z <= fin_in[AX_Z];
      end
   end

   // output register plus skid; the pipeline only moves while the skid is empty
   always_comb begin
      out_v_in = out_v_ff;
      out_d_in = out_d_ff;
      sk_v_in  = sk_v_ff;
      sk_d_in  = sk_d_ff;
      if (rsp_ready) begin
         out_v_in = 1'b0;
      end
      if (sk_v_ff) begin
         if (rsp_ready) begin
            out_v_in = 1'b1;
            out_d_in = sk_d_ff;
            sk_v_in  = 1'b0;
         end
      end else if (vld_ff[NST]) begin
         if (!out_v_ff || rsp_ready) begin
            out_v_in = 1'b1;
            out_d_in = fin_ff;
         end else begin
            sk_v_in = 1'b1;
            sk_d_in = fin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff <= out_d_in;
      sk_d_ff  <= sk_d_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_out_x = out_d_ff.x;
   assign rsp_out_y = out_d_ff.y;
   assign rsp_out_z = out_d_ff.z;

endmodule

`default_nettype wire

/* rtl/eapt_checker.sv */
// ----------------------------------------------------------------------------
// eapt_checker
// Port-level checks on the affine point transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module eapt_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input eapt_pkg::coord_type rsp_out_x,
   input eapt_pkg::coord_type rsp_out_y,
   input eapt_pkg::coord_type rsp_out_z
);
   import eapt_pkg::*;

   localparam int MAX_OUT = NST + 2;
   localparam int CNT_W   = $clog2(MAX_OUT + 2);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             in_acc, out_acc;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (in_acc && !out_acc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (out_acc && !in_acc) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z))
      else $error("result changed while stalled");

   // backpressure only once results are waiting
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // never a result without an item in flight
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !rsp_valid)
      else $error("result with nothing outstanding");

   // in-flight items bounded by the pipeline depth and output buffer
   a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_OUT))
      else $error("too many items in flight");

   // output is empty right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind euler_affine_point_transform eapt_checker u_eapt_checker (.*);

`default_nettype wire
